@@ src/key_debounce_event_detector_assert.svh @@
// Assertion macros shared by the key debounce event detector modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
// Define ASSERT_OFF to compile the checks out.
`ifndef KEY_DEBOUNCE_EVENT_DETECTOR_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled in reset
`define KDED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset
`define KDED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KDED_ASSERT_NOW(lbl, ante, cons, msg)
`define KDED_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/kded_pkg.sv @@
// Shared types and constants of the key debounce event detector.
// No dependencies; imported by kded_lane, kded_emit and the top level.
package kded_pkg;

    localparam int MASK_W = 4;    // key_mask and raw_keys width
    localparam int TIME_W = 32;   // timestamp width
    localparam int ID_W   = 8;    // key_id width
    localparam int CNT_W  = 4;    // debounce counter width
    localparam int LPT_W  = 16;   // long press threshold width
    localparam int CFG_W  = 16;   // config write data width

    localparam logic [ID_W-1:0]  COMBO_ID  = 8'hFF;
    localparam logic [CNT_W-1:0] DEB_RESET = 4'd3;
    localparam logic [LPT_W-1:0] LPT_RESET = 16'd800;

    // Configuration register indexes
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2,
        EV_COMBO   = 2'd3
    } event_kind_t;

    // Per-key lane findings for the current sample
    typedef struct packed {
        logic fire;        // level change accepted on this sample
        logic level;       // debounced level before this sample
        logic long_held;   // held time at or above threshold
    } lane_stat_t;

endpackage

@@ src/key_debounce_event_detector.sv @@
// Top level of the key debounce event detector: config registers, key lanes,
// event merge and output serializer. Depends on kded_pkg, kded_lane, kded_emit.
//
// Each input word is one sample of the key levels plus a millisecond timestamp.
// One lane per key debounces its level in the same cycle the word is accepted;
// the merge stage builds that sample's events (press, release, long press per
// key in key order, then a combination event) into an event buffer, and the
// output register sends them one word per cycle unless m_tready stalls it, tlast on
// the sample's final event. A sample has 0 to NUM_KEYS+1 events; the next sample
// is taken in the cycle the buffer's last event moves to the output register, so
// the single output register sets the rate. A sample with no events produces no
// output word.
module key_debounce_event_detector
#(
    parameter int NUM_KEYS = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // raw_keys[3:0], now_ms[35:4]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // key_id[7:0], event_kind[9:8],
                                                   // key_mask[13:10], event_time[45:14]
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [kded_pkg::CFG_W-1:0]  cfg_wdata
);
    import kded_pkg::*;

    localparam int EXT_W = (NUM_KEYS > MASK_W) ? NUM_KEYS : MASK_W;
    // Wide enough for the key count and for the constant 2
    localparam int POP_W = $clog2(NUM_KEYS + 2);

    logic [CNT_W-1:0]    deb_cnt_reg;
    logic [LPT_W-1:0]    lpt_reg;
    logic [CNT_W-1:0]    need;
    logic [NUM_KEYS-1:0] last_comb_reg;

    logic                accept;
    logic [MASK_W-1:0]   raw_in;
    logic [TIME_W-1:0]   now_in;
    logic [EXT_W-1:0]    raw_ext;
    logic [NUM_KEYS-1:0] raw_k;
    lane_stat_t          stat [NUM_KEYS];

    logic [NUM_KEYS-1:0] old_deb;
    logic [NUM_KEYS-1:0] new_deb;
    logic [NUM_KEYS-1:0] lane_full [NUM_KEYS+1];
    logic [EXT_W-1:0]    lane_ext  [NUM_KEYS+1];
    logic [POP_W-1:0]    pop;
    logic                two_plus;
    logic [NUM_KEYS:0]   ev_vec;
    event_kind_t         ev_kind [NUM_KEYS+1];
    logic [MASK_W-1:0]   ev_mask [NUM_KEYS+1];

    logic [ID_W-1:0]     out_id;
    event_kind_t         out_kind;
    logic [MASK_W-1:0]   out_mask;
    logic [TIME_W-1:0]   out_time;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_cnt_reg <= DEB_RESET;
            lpt_reg     <= LPT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   deb_cnt_reg <= cfg_wdata[CNT_W-1:0];
                REG_LONG_PRESS: lpt_reg     <= cfg_wdata[LPT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign need = (deb_cnt_reg == '0) ? CNT_W'(1) : deb_cnt_reg;

    // Input unpacking
    assign accept  = s_tvalid && s_tready;
    assign raw_in  = s_tdata[MASK_W-1:0];
    assign now_in  = s_tdata[MASK_W+TIME_W-1:MASK_W];
    assign raw_ext = EXT_W'(raw_in);
    assign raw_k   = raw_ext[NUM_KEYS-1:0];

    // Key lanes
    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lane
        kded_lane u_lane
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .accept          (accept),
            .raw_bit         (raw_k[g]),
            .now_ms          (now_in),
            .need            (need),
            .long_press_time (lpt_reg),
            .stat            (stat[g])
        );
    end

    // Merge: running mask per event, event kinds, combination check
    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            old_deb[i] = stat[i].level;
            new_deb[i] = stat[i].fire ? raw_k[i] : stat[i].level;
        end

        for (int i = 0; i < NUM_KEYS; i++)
        begin
            for (int j = 0; j < NUM_KEYS; j++)
            begin
                lane_full[i][j] = (j <= i) ? new_deb[j] : old_deb[j];
            end
            ev_vec[i] = stat[i].fire;
            if (stat[i].fire && raw_k[i])
            begin
                ev_kind[i] = EV_PRESS;
            end
            else if (stat[i].long_held)
            begin
                ev_kind[i] = EV_LONG;
            end
            else
            begin
                ev_kind[i] = EV_RELEASE;
            end
        end
        lane_full[NUM_KEYS] = new_deb;
        ev_kind[NUM_KEYS]   = EV_COMBO;

        for (int i = 0; i <= NUM_KEYS; i++)
        begin
            lane_ext[i] = EXT_W'(lane_full[i]);
            ev_mask[i]  = lane_ext[i][MASK_W-1:0];
        end

        pop = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            pop = pop + POP_W'(new_deb[i]);
        end
        two_plus         = (pop >= POP_W'(2));
        ev_vec[NUM_KEYS] = two_plus && (new_deb != last_comb_reg);
    end

    // Last reported combination
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_comb_reg <= '0;
        end
        else if (accept)
        begin
            last_comb_reg <= two_plus ? new_deb : '0;
        end
    end

    // Event buffer and output serializer
    kded_emit #(.NUM_KEYS(NUM_KEYS)) u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .ev_vec    (ev_vec),
        .ev_kind   (ev_kind),
        .ev_mask   (ev_mask),
        .ev_time   (now_in),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_id    (out_id),
        .out_kind  (out_kind),
        .out_mask  (out_mask),
        .out_time  (out_time),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_time, out_mask, out_kind, out_id};

endmodule

@@ src/kded_lane.sv @@
// One key lane: change counter, debounced level and press timestamp.
// Depends on kded_pkg and the assertion macro header.
`include "key_debounce_event_detector_assert.svh"

module kded_lane
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        raw_bit,
    input  logic [kded_pkg::TIME_W-1:0] now_ms,
    input  logic [kded_pkg::CNT_W-1:0]  need,
    input  logic [kded_pkg::LPT_W-1:0]  long_press_time,
    output kded_pkg::lane_stat_t        stat
);
    import kded_pkg::*;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              deb_reg;
    logic [TIME_W-1:0] press_reg;
    logic [TIME_W-1:0] held;
    logic              fire;

    // Count samples that disagree with the debounced level
    always_comb
    begin
        if (raw_bit != deb_reg)
        begin
            cnt_next = (cnt_reg < need) ? cnt_reg + 1'b1 : cnt_reg;
        end
        else
        begin
            cnt_next = '0;
        end
        fire = (cnt_next >= need);
        held = now_ms - press_reg;   // wraps mod 2^32
        stat.fire      = fire;
        stat.level     = deb_reg;
        stat.long_held = (held >= TIME_W'(long_press_time));
    end

    // Lane state update on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            deb_reg   <= 1'b0;
            press_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= fire ? '0 : cnt_next;
            if (fire)
            begin
                deb_reg <= raw_bit;
            end
            if (fire && raw_bit)
            begin
                press_reg <= now_ms;
            end
        end
    end

    `KDED_ASSERT_NEXT(a_fire_clears_cnt, accept && fire, cnt_reg == '0,
        "counter not cleared after accepted change")
    `KDED_ASSERT_NEXT(a_fire_sets_level, accept && fire, deb_reg == $past(raw_bit),
        "debounced level does not follow accepted change")
    `KDED_ASSERT_NEXT(a_press_time, accept && fire && raw_bit, press_reg == $past(now_ms),
        "press time not captured")

endmodule

@@ src/kded_emit.sv @@
// Event buffer and output word register: drains one sample's events in order.
// Depends on kded_pkg and the assertion macro header.
`include "key_debounce_event_detector_assert.svh"

module kded_emit
#(
    parameter int NUM_KEYS = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [NUM_KEYS:0]           ev_vec,
    input  kded_pkg::event_kind_t       ev_kind [NUM_KEYS+1],
    input  logic [kded_pkg::MASK_W-1:0] ev_mask [NUM_KEYS+1],
    input  logic [kded_pkg::TIME_W-1:0] ev_time,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [kded_pkg::ID_W-1:0]   out_id,
    output kded_pkg::event_kind_t       out_kind,
    output logic [kded_pkg::MASK_W-1:0] out_mask,
    output logic [kded_pkg::TIME_W-1:0] out_time,
    output logic                        out_last
);
    import kded_pkg::*;

    localparam int SEL_W = $clog2(NUM_KEYS + 1);

    logic [NUM_KEYS:0]  pend_reg;
    logic [NUM_KEYS:0]  pend_rest;
    logic [NUM_KEYS:0]  pend_next;
    event_kind_t        kind_reg [NUM_KEYS+1];
    logic [MASK_W-1:0]  mask_reg [NUM_KEYS+1];
    logic [TIME_W-1:0]  time_reg;
    logic [SEL_W-1:0]   sel;
    logic               move;

    logic               out_valid_reg;
    logic [ID_W-1:0]    out_id_reg;
    event_kind_t        out_kind_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic               out_last_reg;

    // Lowest pending event goes next
    always_comb
    begin
        sel = '0;
        for (int i = NUM_KEYS; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = SEL_W'(i);
            end
        end
        pend_rest = pend_reg & (pend_reg - 1'b1);
        move      = (|pend_reg) && (!out_valid_reg || out_ready);
        pend_next = move ? pend_rest : pend_reg;
        ready     = (pend_next == '0);
    end

    // Pending set and buffered event payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= load ? ev_vec : pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= ev_kind;
            mask_reg <= ev_mask;
            time_reg <= ev_time;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_id_reg   <= (sel == SEL_W'(NUM_KEYS)) ? COMBO_ID : ID_W'(sel);
            out_kind_reg <= kind_reg[sel];
            out_mask_reg <= mask_reg[sel];
            out_time_reg <= time_reg;
            out_last_reg <= (pend_rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_kind  = out_kind_reg;
    assign out_mask  = out_mask_reg;
    assign out_time  = out_time_reg;
    assign out_last  = out_last_reg;

    `KDED_ASSERT_NOW(a_load_when_free, load, ready,
        "sample loaded while events still pending")
    `KDED_ASSERT_NEXT(a_hold_pending, (pend_reg != '0) && !move, $stable(pend_reg),
        "pending events changed without a move")
    `KDED_ASSERT_NEXT(a_move_valid, move, out_valid_reg,
        "event moved but output word not valid")
    `KDED_ASSERT_NEXT(a_last_empties, move && (pend_rest == '0) && !load,
        pend_reg == '0, "last word sent but events remain")

endmodule

@@ tb/sv/key_debounce_event_detector_test.sv @@
// Self-checking testbench for key_debounce_event_detector: streams key samples,
// predicts the event words in a scoreboard class and checks every output word.
// Depends on kded_pkg and the key_debounce_event_detector RTL.
`timescale 1ns / 1ps

module key_debounce_event_detector_test;

    import kded_pkg::*;

    // One expected or observed event word
    typedef struct packed {
        logic [7:0]  key_id;
        event_kind_t kind;
        logic [3:0]  mask;
        logic [31:0] stamp;
        logic        last;
    } key_event_t;

    // Event predictor and store of pending events
    class key_event_board;
        logic [3:0]  deb_setting;
        logic [15:0] long_limit;
        logic [3:0]  keys_down;
        logic [3:0]  streak [4];
        logic [31:0] down_at [4];
        logic [3:0]  combo_shown;
        key_event_t  pending [$];
        int          mismatches;

        function new();
            deb_setting = DEB_RESET;
            long_limit  = LPT_RESET;
            keys_down   = '0;
            combo_shown = '0;
            mismatches  = 0;
            foreach (streak[i])
            begin
                streak[i]  = '0;
                down_at[i] = '0;
            end
        endfunction

        function void write_reg(logic idx, logic [15:0] value);
            if (idx == REG_DEBOUNCE)
                deb_setting = value[3:0];
            else
                long_limit = value;
        endfunction

        // Debounce one sample and queue the events it causes
        function void note_sample(logic [3:0] raw, logic [31:0] now);
            key_event_t batch [$];
            key_event_t ev;
            logic [3:0]  need;
            logic [31:0] held;
            need = (deb_setting == 4'd0) ? 4'd1 : deb_setting;
            for (int i = 0; i < 4; i++)
            begin
                if (raw[i] != keys_down[i])
                begin
                    if (streak[i] < need)
                        streak[i]++;
                end
                else
                    streak[i] = '0;
                if (streak[i] >= need)
                begin
                    keys_down[i] = raw[i];
                    streak[i]    = '0;
                    ev.key_id    = 8'(i);
                    ev.mask      = keys_down;
                    ev.stamp     = now;
                    ev.last      = 1'b0;
                    if (keys_down[i])
                    begin
                        down_at[i] = now;
                        ev.kind    = EV_PRESS;
                    end
                    else
                    begin
                        held    = now - down_at[i];
                        ev.kind = (held >= {16'd0, long_limit}) ? EV_LONG : EV_RELEASE;
                    end
                    batch.push_back(ev);
                end
            end
            // combination: two or more keys down and a new set
            if ($countones(keys_down) >= 2 && keys_down != combo_shown)
            begin
                ev.key_id = COMBO_ID;
                ev.kind   = EV_COMBO;
                ev.mask   = keys_down;
                ev.stamp  = now;
                ev.last   = 1'b0;
                batch.push_back(ev);
            end
            combo_shown = ($countones(keys_down) >= 2) ? keys_down : 4'd0;
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j])
                pending.push_back(batch[j]);
        endfunction

        // Compare one output word with the oldest pending event
        function void check_event(logic [47:0] word, logic last_flag);
            key_event_t want;
            key_event_t got;
            got.key_id = word[7:0];
            got.kind   = event_kind_t'(word[9:8]);
            got.mask   = word[13:10];
            got.stamp  = word[45:14];
            got.last   = last_flag;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected event id=%0d kind=%0d mask=%h time=%h last=%b",
                             got.key_id, got.kind, got.mask, got.stamp, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.key_id !== want.key_id || got.kind !== want.kind ||
                got.mask !== want.mask || got.stamp !== want.stamp || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: event mismatch: expected id=%0d kind=%0d mask=%h time=%h last=%b",
                             want.key_id, want.kind, want.mask, want.stamp, want.last);
                    $display("       got id=%0d kind=%0d mask=%h time=%h last=%b",
                             got.key_id, got.kind, got.mask, got.stamp, got.last);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // raw_keys[3:0], now_ms[35:4]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // key_id[7:0], event_kind[9:8], key_mask[13:10],
                                    // event_time[45:14]
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    key_event_board board;
    int          idle_pct = 0;
    int          deb_need = 3;
    logic [31:0] clock_ms = 32'h0000_1000;

    key_debounce_event_detector DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Watch both handshakes on the pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_sample(s_tdata[3:0], s_tdata[35:4]);
            if (m_tvalid && m_tready)
                board.check_event(m_tdata, m_tlast);
        end
    end

    // Output back-pressure in random bursts
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < idle_pct / 2)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Present one sample word, returns at the edge that takes it
    task automatic send_sample(logic [3:0] raw, logic [31:0] now);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, now, raw};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic hold_keys(logic [3:0] raw, logic [31:0] start, int n);
        for (int k = 0; k < n; k++)
            send_sample(raw, start + 32'(k));
    endtask

    // Stop sending and let every pending event come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        // let the last accepted sample reach the scoreboard first
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] deb, logic [15:0] lpt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= {12'd0, deb};
        @(posedge clk);
        board.write_reg(REG_DEBOUNCE, {12'd0, deb});
        cfg_index <= REG_LONG_PRESS;
        cfg_wdata <= lpt;
        @(posedge clk);
        board.write_reg(REG_LONG_PRESS, lpt);
        cfg_we   <= 1'b0;
        deb_need = (deb == 4'd0) ? 1 : int'(deb);
    endtask

    // Mostly short ticks, sometimes long holds or a jump anywhere
    task automatic advance_ms();
        case ($urandom_range(0, 19))
            0:       clock_ms = $urandom;
            1:       clock_ms += $urandom_range(60000, 70000);
            2, 3, 4, 5: clock_ms += $urandom_range(0, 1600);
            default: clock_ms += $urandom_range(1, 3);
        endcase
    endtask

    // Held patterns long enough to settle, mixed with short glitches
    task automatic run_random(int n);
        int sent;
        int reps;
        logic [3:0] target;
        sent = 0;
        while (sent < n)
        begin
            target = 4'($urandom);
            if ($urandom_range(0, 4) == 0)
                reps = $urandom_range(1, deb_need);
            else
                reps = deb_need + $urandom_range(0, 2);
            for (int k = 0; k < reps && sent < n; k++)
            begin
                advance_ms();
                send_sample(target, clock_ms);
                sent++;
            end
        end
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset settings (count 3, threshold 800)
        idle_pct = 20;
        hold_keys(4'hF, 32'd1, 3);              // all four pressed: four presses and a combo
        send_sample(4'h0, 32'd4);               // one-sample glitch is filtered
        send_sample(4'hF, 32'd5);
        hold_keys(4'h1, 32'd800, 3);            // held 799: plain releases, combo cleared
        hold_keys(4'h0, 32'd801, 3);            // held exactly the threshold: long press
        hold_keys(4'h3, 32'hFFFF_FFFD, 3);      // pair pressed at the top of the time range
        hold_keys(4'h1, 32'h0000_031E, 3);      // held time wraps through zero: long press
        hold_keys(4'h3, 32'h0000_0400, 3);      // same pair again is reported again
        hold_keys(4'h0, 32'h0000_0500, 3);

        // Random phases over several settings, extremes included
        wait_drain();
        set_config(4'd0, 16'd0);                // zero count acts as one; every release long
        idle_pct = 30;
        run_random(40);
        wait_drain();
        set_config(4'd15, 16'hFFFF);
        idle_pct = 20;
        run_random(37);
        wait_drain();
        set_config(4'd1, 16'($urandom_range(1, 1000)));
        idle_pct = 50;
        run_random(45);
        wait_drain();
        set_config(4'd2, 16'd100);
        idle_pct = 10;
        run_random(45);
        wait_drain();
        set_config(4'd5, 16'd1500);
        idle_pct = 0;
        run_random(40);
        wait_drain();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
